/* design/d2q_pkg.sv */
// Shared constants, types and helper functions for the D2Q9 BGK node collide unit.
// Used by d2q_vel_div, d2q_lane and d2q9_bgk_node_collide_unit. No dependencies.
`default_nettype none
package d2q_pkg;

  localparam int FRAC_BITS_DEF = 24;
  localparam int DATA_W        = 32;
  localparam int NDIR          = 9;
  localparam int KIND_W        = 2;
  localparam int RELAX_W       = 26;
  localparam int LID_W         = 24;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;

  // momentum sums of six 32-bit terms
  localparam int MOM_W = 35;
  // quotient bits of the velocity divider (result magnitude below 2^31)
  localparam int DQ_W  = 31;
  // squared terms after the fraction shift, FRAC_BITS >= 16
  localparam int SQ_W  = 48;
  // bracket accumulator
  localparam int B_W   = 56;
  // clamped dividend of the divide-by-nine
  localparam int X_W   = 36;
  localparam int D9_BITS   = 6;
  localparam int D9_STAGES = X_W / D9_BITS;

  // pipeline depths
  localparam int DIV_LAT  = DQ_W + 2;
  localparam int LANE_LAT = D9_STAGES + 6;

  localparam logic [KIND_W-1:0] KIND_FLUID = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LID   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RELAX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LID   = 2'd1;

  localparam logic [RELAX_W-1:0]     RELAX_RESET = 26'd31655125;
  localparam logic signed [LID_W-1:0] LID_RESET  = 24'sd1677722;

  // direction order: rest, down, right, up, left, right_down, right_up, left_up, left_down
  localparam int DIR_CX [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
  localparam int DIR_CY [NDIR] = '{0, -1, 0, 1, 0, -1, 1, 1, -1};
  // weight n/(d*2^F) = 1/(9*2^(F+WT_SHIFT)): 2/9, 1/18, 1/72
  localparam int WT_SHIFT [NDIR] = '{-1, 1, 1, 1, 1, 3, 3, 3, 3};

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct packed {
    logic [D9_BITS-1:0] q;
    logic [3:0]         rem;
  } d9_step_t;

  localparam logic signed [63:0] S32_MAX64 = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN64 = -64'sd2147483648;

  function automatic word_t sat32(input logic signed [63:0] x);
    word_t r;
    if (x > S32_MAX64) begin
      r = 32'sh7FFFFFFF;
    end else if (x < S32_MIN64) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // a few bits of long division by nine
  function automatic d9_step_t div9_step(input logic [3:0] rem_in,
                                         input logic [D9_BITS-1:0] bits);
    logic [4:0] t;
    logic [3:0] r;
    d9_step_t   res;
    r = rem_in;
    res.q = '0;
    for (int k = D9_BITS - 1; k >= 0; k--) begin
      t = {r, bits[k]};
      if (t >= 5'd9) begin
        res.q[k] = 1'b1;
        r = 4'(t - 5'd9);
      end else begin
        r = t[3:0];
      end
    end
    res.rem = r;
    return res;
  endfunction

endpackage
`default_nettype wire

/* design/d2q_vel_div.sv */
// Pipelined restoring divider for one velocity component: trunc(num * 2^F / den),
// saturated to 32 bits, one quotient bit per stage. Depends on d2q_pkg.
`default_nettype none
module d2q_vel_div #(
  parameter int FRAC_BITS = d2q_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic signed [d2q_pkg::MOM_W-1:0]  num,
  input  wire logic        [d2q_pkg::DQ_W-1:0]   den,
  output d2q_pkg::word_t                         quot
);

  localparam int MW = d2q_pkg::MOM_W;
  localparam int QW = d2q_pkg::DQ_W;

  logic [MW-1:0]    mag;
  logic [MW-1:0]    r0;
  logic [MW+QW-1:0] wide;
  logic             ovf0;

  logic [QW-1:0] rem   [0:QW];
  logic [QW-1:0] low   [0:QW];
  logic [QW-1:0] q     [0:QW];
  logic [QW-1:0] den_p [0:QW];
  logic          neg   [0:QW];
  logic          ovf   [0:QW];

  always_comb begin
    mag  = num[MW-1] ? MW'(-num) : MW'(num);
    r0   = mag >> (d2q_pkg::DATA_W - 1 - FRAC_BITS);
    ovf0 = r0 >= MW'(den);
    wide = {{QW{1'b0}}, mag} << FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    rem[0]   <= ovf0 ? '0 : r0[QW-1:0];
    low[0]   <= wide[QW-1:0];
    q[0]     <= '0;
    den_p[0] <= den;
    neg[0]   <= num[MW-1];
    ovf[0]   <= ovf0;
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [QW:0] t;
    logic [QW:0] diff;
    logic        ge;
    always_comb begin
      t    = {rem[k], low[k][QW-1]};
      diff = t - {1'b0, den_p[k]};
      ge   = t >= {1'b0, den_p[k]};
    end
    always_ff @(posedge clk) begin
      rem[k+1]   <= ge ? diff[QW-1:0] : t[QW-1:0];
      q[k+1]     <= {q[k][QW-2:0], ge};
      low[k+1]   <= low[k] << 1;
      den_p[k+1] <= den_p[k];
      neg[k+1]   <= neg[k];
      ovf[k+1]   <= ovf[k];
    end
  end

  always_ff @(posedge clk) begin
    if (ovf[QW]) begin
      quot <= neg[QW] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else if (neg[QW]) begin
      quot <= -$signed({1'b0, q[QW]});
    end else begin
      quot <= $signed({1'b0, q[QW]});
    end
  end

endmodule
`default_nettype wire

/* design/d2q_lane.sv */
// One direction of the collision: BGK bracket, equilibrium via density product and
// divide-by-nine pipeline, then relaxation by omega. Depends on d2q_pkg.
`default_nettype none
module d2q_lane #(
  parameter int FRAC_BITS = d2q_pkg::FRAC_BITS_DEF,
  parameter int DIR       = 0
) (
  input  wire logic                             clk,
  input  wire logic signed [d2q_pkg::DATA_W-1:0] cu,
  input  wire logic [d2q_pkg::SQ_W-1:0]          cu_sq,
  input  wire logic [d2q_pkg::SQ_W-1:0]          usq,
  input  wire logic signed [d2q_pkg::DATA_W-1:0] rho,
  input  wire logic signed [d2q_pkg::DATA_W-1:0] f,
  input  wire logic [d2q_pkg::RELAX_W-1:0]       omega,
  output d2q_pkg::word_t                         post
);

  localparam int BW  = d2q_pkg::B_W;
  localparam int XW  = d2q_pkg::X_W;
  localparam int NS  = d2q_pkg::D9_STAGES;
  localparam int DB  = d2q_pkg::D9_BITS;
  localparam int SH  = FRAC_BITS + d2q_pkg::WT_SHIFT[DIR];
  localparam logic signed [BW-1:0] TWO_ONE = BW'(2) << FRAC_BITS;

  // bracket stage
  logic signed [BW-1:0] b_full;
  d2q_pkg::word_t       b2, rho_b, f_b;

  always_comb begin
    b_full = TWO_ONE + 6 * BW'(cu) + 9 * $signed(BW'(cu_sq)) - 3 * $signed(BW'(usq));
  end

  always_ff @(posedge clk) begin
    b2    <= d2q_pkg::sat32(64'(b_full));
    rho_b <= rho;
    f_b   <= f;
  end

  // density product stage
  logic signed [63:0] prod;
  logic [62:0]        pmag;
  logic               psgn_p;
  d2q_pkg::word_t     f_p;

  always_comb prod = 64'(rho_b) * 64'(b2);

  always_ff @(posedge clk) begin
    pmag   <= prod[63] ? 63'(-prod) : prod[62:0];
    psgn_p <= prod[63];
    f_p    <= f_b;
  end

  // weight shift and clamp; results that large saturate anyway
  logic [62:0] xs;
  always_comb xs = pmag >> SH;

  logic [XW-1:0]  xr  [0:NS];
  logic [XW-1:0]  q9  [0:NS];
  logic [3:0]     r9  [0:NS];
  logic           sgn [0:NS];
  d2q_pkg::word_t f9  [0:NS];

  always_ff @(posedge clk) begin
    xr[0]  <= (|xs[62:XW]) ? {XW{1'b1}} : xs[XW-1:0];
    q9[0]  <= '0;
    r9[0]  <= '0;
    sgn[0] <= psgn_p;
    f9[0]  <= f_p;
  end

  for (genvar k = 0; k < NS; k++) begin : g_div9
    d2q_pkg::d9_step_t st;
    always_comb st = d2q_pkg::div9_step(r9[k], xr[k][XW-1 -: DB]);
    always_ff @(posedge clk) begin
      xr[k+1]  <= xr[k] << DB;
      q9[k+1]  <= {q9[k][XW-DB-1:0], st.q};
      r9[k+1]  <= st.rem;
      sgn[k+1] <= sgn[k];
      f9[k+1]  <= f9[k];
    end
  end

  // equilibrium with sign and saturation
  logic [XW-1:0]  fm;
  d2q_pkg::word_t feq, f_e;

  always_comb fm = q9[NS];

  always_ff @(posedge clk) begin
    if (!sgn[NS]) begin
      feq <= (fm > XW'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : $signed(fm[31:0]);
    end else begin
      feq <= (fm > XW'(32'h80000000)) ? 32'sh80000000 : $signed(-fm[31:0]);
    end
    f_e <= f9[NS];
  end

  // relaxation product
  logic signed [32:0] diff;
  logic [32:0]        dmag;
  logic [58:0]        dprod;
  logic [58:0]        dm;
  logic               dneg;
  d2q_pkg::word_t     f_d;

  always_comb begin
    diff  = 33'(feq) - 33'(f_e);
    dmag  = diff[32] ? 33'(-diff) : 33'(diff);
    dprod = 59'(dmag) * 59'(omega);
  end

  always_ff @(posedge clk) begin
    dm   <= dprod >> FRAC_BITS;
    dneg <= diff[32];
    f_d  <= f_e;
  end

  logic signed [60:0] s;
  always_comb s = 61'(f_d) + (dneg ? -$signed(61'(dm)) : $signed(61'(dm)));

  always_ff @(posedge clk) begin
    post <= d2q_pkg::sat32(64'(s));
  end

endmodule
`default_nettype wire

/* design/d2q9_bgk_node_collide_unit.sv */
// Top level of the D2Q9 BGK node collide unit: moments, velocity dividers,
// equilibrium lanes. Depends on d2q_pkg, d2q_vel_div and d2q_lane.
//
// Usage:
//  - Raise start with node_kind and the nine dist_* values; the request is taken
//    at every rising edge where start is high and busy is low. busy is high during
//    reset and in the first cycle after it, so one node can be issued every clock.
//  - Each result shows up on post_*, density, vel_x and vel_y for one cycle with
//    done high, in request order.
//  - Pipeline: the input register loads at the request edge, then the moment
//    registers, the two parallel velocity dividers (one quotient bit per stage),
//    velocity select, cu and squares, then the nine lanes (bracket, density
//    product, weight shift and clamp, six-stage divide by nine, equilibrium,
//    relax).
//  - Throughput: one node per cycle, fully pipelined.
//  - Config: cfg_valid/cfg_ready write channel, always ready. Index 0 is omega
//    (relax_rate, unsigned Q.F), index 1 the lid speed (signed Q.F). Write only
//    while no request is in flight.
//  - Reset (synchronous, rst high) clears all valid bits and loads the default
//    omega and lid speed; requests in flight are dropped.
//  - Results cannot be held off by the receiver; done must be taken when seen.
`default_nettype none
module d2q9_bgk_node_collide_unit #(
  parameter int FRAC_BITS = d2q_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [d2q_pkg::KIND_W-1:0]           node_kind,
  input  wire logic signed [d2q_pkg::DATA_W-1:0]    dist_rest,
  input  wire logic signed [d2q_pkg::DATA_W-1:0]    dist_down,
  input  wire logic signed [d2q_pkg::DATA_W-1:0]    dist_right,
  input  wire logic signed [d2q_pkg::DATA_W-1:0]    dist_up,
  input  wire logic signed [d2q_pkg::DATA_W-1:0]    dist_left,
  input  wire logic signed [d2q_pkg::DATA_W-1:0]    dist_right_down,
  input  wire logic signed [d2q_pkg::DATA_W-1:0]    dist_right_up,
  input  wire logic signed [d2q_pkg::DATA_W-1:0]    dist_left_up,
  input  wire logic signed [d2q_pkg::DATA_W-1:0]    dist_left_down,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [d2q_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [d2q_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                      done,
  output d2q_pkg::word_t                            post_rest,
  output d2q_pkg::word_t                            post_down,
  output d2q_pkg::word_t                            post_right,
  output d2q_pkg::word_t                            post_up,
  output d2q_pkg::word_t                            post_left,
  output d2q_pkg::word_t                            post_right_down,
  output d2q_pkg::word_t                            post_right_up,
  output d2q_pkg::word_t                            post_left_up,
  output d2q_pkg::word_t                            post_left_down,
  output d2q_pkg::word_t                            density,
  output d2q_pkg::word_t                            vel_x,
  output d2q_pkg::word_t                            vel_y
);

  localparam int ND    = d2q_pkg::NDIR;
  localparam int MW    = d2q_pkg::MOM_W;
  localparam int SUM_W = 36;
  localparam int DLAT  = d2q_pkg::DIV_LAT;
  localparam int LLAT  = d2q_pkg::LANE_LAT;
  localparam int SQW   = d2q_pkg::SQ_W;

  typedef struct packed {
    logic [d2q_pkg::KIND_W-1:0]    kind;
    d2q_pkg::word_t                rho;
    d2q_pkg::word_t [ND-1:0]       f;
  } node_t;

  typedef struct packed {
    d2q_pkg::word_t rho;
    d2q_pkg::word_t u;
    d2q_pkg::word_t v;
  } macro_t;

  // config registers
  logic [d2q_pkg::RELAX_W-1:0]      relax_rate;
  logic signed [d2q_pkg::LID_W-1:0] lid_speed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      relax_rate <= d2q_pkg::RELAX_RESET;
      lid_speed  <= d2q_pkg::LID_RESET;
      busy       <= 1'b1;
    end else begin
      busy <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          d2q_pkg::REG_RELAX: relax_rate <= cfg_data[d2q_pkg::RELAX_W-1:0];
          d2q_pkg::REG_LID:   lid_speed  <= $signed(cfg_data[d2q_pkg::LID_W-1:0]);
          default: ;
        endcase
      end
    end
  end

  // input register
  d2q_pkg::word_t [ND-1:0]    f_in;
  d2q_pkg::word_t [ND-1:0]    f0;
  logic [d2q_pkg::KIND_W-1:0] kind0;
  logic                       v0;

  always_comb begin
    f_in[0] = dist_rest;
    f_in[1] = dist_down;
    f_in[2] = dist_right;
    f_in[3] = dist_up;
    f_in[4] = dist_left;
    f_in[5] = dist_right_down;
    f_in[6] = dist_right_up;
    f_in[7] = dist_left_up;
    f_in[8] = dist_left_down;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    f0    <= f_in;
    kind0 <= node_kind;
  end

  // density and momentum
  logic signed [SUM_W-1:0] rho_sum;
  logic signed [MW-1:0]    mx, my;
  node_t                   n1;
  logic signed [MW-1:0]    mx1, my1;
  logic                    v1;

  always_comb begin
    if (kind0 == d2q_pkg::KIND_LID) begin
      rho_sum = SUM_W'(f0[0]) + SUM_W'(f0[2]) + SUM_W'(f0[4])
              + ((SUM_W'(f0[3]) + SUM_W'(f0[6]) + SUM_W'(f0[7])) <<< 1);
    end else begin
      rho_sum = SUM_W'(f0[0]) + SUM_W'(f0[1]) + SUM_W'(f0[2]) + SUM_W'(f0[3])
              + SUM_W'(f0[4]) + SUM_W'(f0[5]) + SUM_W'(f0[6]) + SUM_W'(f0[7])
              + SUM_W'(f0[8]);
    end
    mx = MW'(f0[2]) - MW'(f0[4]) + MW'(f0[5]) + MW'(f0[6]) - MW'(f0[7]) - MW'(f0[8]);
    my = MW'(f0[3]) - MW'(f0[1]) - MW'(f0[5]) + MW'(f0[6]) + MW'(f0[7]) - MW'(f0[8]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    n1.kind <= kind0;
    n1.rho  <= d2q_pkg::sat32(64'(rho_sum));
    n1.f    <= f0;
    mx1     <= mx;
    my1     <= my;
  end

  // velocity dividers
  logic [d2q_pkg::DQ_W-1:0] den;
  d2q_pkg::word_t           qx, qy;

  assign den = (n1.rho > 0) ? n1.rho[d2q_pkg::DQ_W-1:0] : d2q_pkg::DQ_W'(1);

  d2q_vel_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk  (clk),
    .num  (mx1),
    .den  (den),
    .quot (qx)
  );

  d2q_vel_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk  (clk),
    .num  (my1),
    .den  (den),
    .quot (qy)
  );

  node_t ndly [0:DLAT-1];
  logic  vdly [0:DLAT-1];

  always_ff @(posedge clk) begin
    ndly[0] <= n1;
    for (int k = 1; k < DLAT; k++) begin
      ndly[k] <= ndly[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DLAT; k++) begin
        vdly[k] <= 1'b0;
      end
    end else begin
      vdly[0] <= v1;
      for (int k = 1; k < DLAT; k++) begin
        vdly[k] <= vdly[k-1];
      end
    end
  end

  // velocity select
  node_t          nd;
  node_t          nv;
  d2q_pkg::word_t u_v, v_v;
  logic           vv;

  assign nd = ndly[DLAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vv <= 1'b0;
    end else begin
      vv <= vdly[DLAT-1];
    end
  end

  always_ff @(posedge clk) begin
    nv <= nd;
    if (nd.rho > 0 && nd.kind == d2q_pkg::KIND_FLUID) begin
      u_v <= qx;
      v_v <= qy;
    end else if (nd.rho > 0 && nd.kind == d2q_pkg::KIND_LID) begin
      u_v <= 32'(lid_speed);
      v_v <= '0;
    end else begin
      u_v <= '0;
      v_v <= '0;
    end
  end

  // cu per direction
  d2q_pkg::word_t [ND-1:0] cu_c;
  d2q_pkg::word_t          u_c, v_c, rho_c;
  d2q_pkg::word_t [ND-1:0] f_c;
  logic                    vc;
  logic signed [33:0]      ue, ve;

  assign ue = 34'(u_v);
  assign ve = 34'(v_v);

  for (genvar i = 0; i < ND; i++) begin : g_cu
    localparam int CX = d2q_pkg::DIR_CX[i];
    localparam int CY = d2q_pkg::DIR_CY[i];
    logic signed [33:0] tx, ty;
    always_comb begin
      tx = (CX > 0) ? ue : ((CX < 0) ? -ue : 34'sd0);
      ty = (CY > 0) ? ve : ((CY < 0) ? -ve : 34'sd0);
    end
    always_ff @(posedge clk) begin
      cu_c[i] <= d2q_pkg::sat32(64'(tx + ty));
    end
  end

  always_ff @(posedge clk) begin
    u_c   <= u_v;
    v_c   <= v_v;
    rho_c <= nv.rho;
    f_c   <= nv.f;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else begin
      vc <= vv;
    end
  end

  // squares
  d2q_pkg::word_t [ND-1:0] cu_q;
  logic [SQW-1:0]          csq [ND];
  logic [SQW-1:0]          usq_q;
  d2q_pkg::word_t          u_q, v_q, rho_q;
  d2q_pkg::word_t [ND-1:0] f_q;
  logic                    vq;

  for (genvar i = 0; i < ND; i++) begin : g_sq
    logic [31:0] m;
    logic [63:0] sq;
    always_comb begin
      m  = cu_c[i][31] ? 32'(-cu_c[i]) : 32'(cu_c[i]);
      sq = 64'(m) * 64'(m);
    end
    always_ff @(posedge clk) begin
      csq[i] <= SQW'(sq >> FRAC_BITS);
    end
  end

  logic [31:0] mu, mv;
  logic [63:0] squ, sqv;

  always_comb begin
    mu  = u_c[31] ? 32'(-u_c) : 32'(u_c);
    mv  = v_c[31] ? 32'(-v_c) : 32'(v_c);
    squ = 64'(mu) * 64'(mu);
    sqv = 64'(mv) * 64'(mv);
  end

  always_ff @(posedge clk) begin
    usq_q <= SQW'(squ >> FRAC_BITS) + SQW'(sqv >> FRAC_BITS);
    cu_q  <= cu_c;
    u_q   <= u_c;
    v_q   <= v_c;
    rho_q <= rho_c;
    f_q   <= f_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= 1'b0;
    end else begin
      vq <= vc;
    end
  end

  // lanes
  d2q_pkg::word_t [ND-1:0] post;

  for (genvar i = 0; i < ND; i++) begin : g_lane
    d2q_lane #(.FRAC_BITS(FRAC_BITS), .DIR(i)) u_lane (
      .clk   (clk),
      .cu    (cu_q[i]),
      .cu_sq (csq[i]),
      .usq   (usq_q),
      .rho   (rho_q),
      .f     (f_q[i]),
      .omega (relax_rate),
      .post  (post[i])
    );
  end

  macro_t mdly [0:LLAT-1];
  logic   vl   [0:LLAT-1];

  always_ff @(posedge clk) begin
    mdly[0] <= '{rho: rho_q, u: u_q, v: v_q};
    for (int k = 1; k < LLAT; k++) begin
      mdly[k] <= mdly[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LLAT; k++) begin
        vl[k] <= 1'b0;
      end
    end else begin
      vl[0] <= vq;
      for (int k = 1; k < LLAT; k++) begin
        vl[k] <= vl[k-1];
      end
    end
  end

  assign done            = vl[LLAT-1];
  assign density         = mdly[LLAT-1].rho;
  assign vel_x           = mdly[LLAT-1].u;
  assign vel_y           = mdly[LLAT-1].v;
  assign post_rest       = post[0];
  assign post_down       = post[1];
  assign post_right      = post[2];
  assign post_up         = post[3];
  assign post_left       = post[4];
  assign post_right_down = post[5];
  assign post_right_up   = post[6];
  assign post_left_up    = post[7];
  assign post_left_down  = post[8];

endmodule
`default_nettype wire

/* test/tb.sv */
// Self-checking bench for d2q9_bgk_node_collide_unit: random and directed nodes,
// predicted in-bench with a fixed-point BGK collision. Depends on d2q_pkg and the RTL.
`default_nettype none
module tb;

  localparam int FB = d2q_pkg::FRAC_BITS_DEF;
  localparam int LAT = 49;
  localparam int WATCH_LIMIT = 2000;
  localparam int NDIR = d2q_pkg::NDIR;

  typedef struct packed {
    logic [d2q_pkg::KIND_W-1:0] kind;
    d2q_pkg::word_t [NDIR-1:0] f;
  } node_t;

  typedef struct packed {
    d2q_pkg::word_t [NDIR-1:0] post;
    d2q_pkg::word_t rho;
    d2q_pkg::word_t ux;
    d2q_pkg::word_t uy;
  } coll_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [d2q_pkg::KIND_W-1:0] node_kind = '0;
  d2q_pkg::word_t dist_in [NDIR];
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [d2q_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [d2q_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic done;
  d2q_pkg::word_t post [NDIR];
  d2q_pkg::word_t density, vel_x, vel_y;

  string post_name [NDIR] = '{"post_rest", "post_down", "post_right", "post_up",
                              "post_left", "post_right_down", "post_right_up",
                              "post_left_up", "post_left_down"};

  logic [d2q_pkg::RELAX_W-1:0] omega_q;
  logic signed [d2q_pkg::LID_W-1:0] lid_q;
  coll_t expected_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int nodes_sent = 0;
  int results_seen = 0;

  initial for (int i = 0; i < NDIR; i++) dist_in[i] = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  d2q9_bgk_node_collide_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .node_kind(node_kind),
    .dist_rest(dist_in[0]), .dist_down(dist_in[1]), .dist_right(dist_in[2]),
    .dist_up(dist_in[3]), .dist_left(dist_in[4]), .dist_right_down(dist_in[5]),
    .dist_right_up(dist_in[6]), .dist_left_up(dist_in[7]), .dist_left_down(dist_in[8]),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done),
    .post_rest(post[0]), .post_down(post[1]), .post_right(post[2]), .post_up(post[3]),
    .post_left(post[4]), .post_right_down(post[5]), .post_right_up(post[6]),
    .post_left_up(post[7]), .post_left_down(post[8]),
    .density(density), .vel_x(vel_x), .vel_y(vel_y)
  );

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic logic [63:0] absval(input logic signed [63:0] x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  function automatic logic signed [63:0] velocity_of(input logic signed [63:0] m,
                                                     input logic signed [63:0] rho);
    logic [63:0] a, d, q, r;
    a = absval(m);
    d = 64'(rho);
    q = a / d;
    r = a % d;
    if (q >= (64'd1 << (31 - FB))) return m < 0 ? -64'sd2147483648 : 64'sd2147483647;
    q = (q << FB) + ((r << FB) / d);
    return m < 0 ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [63:0] sq_frac(input logic signed [63:0] x);
    logic [63:0] a;
    a = absval(x);
    return $signed((a * a) >> FB);
  endfunction

  function automatic coll_t collide(input node_t n);
    coll_t res;
    logic signed [63:0] f [NDIR];
    logic signed [63:0] rho, u, v, usq, cu, b2, prod, feq, diff, pv, mx, my;
    logic [127:0] fm;
    logic [63:0] dm;
    int num, den;
    u = 0;
    v = 0;
    for (int i = 0; i < NDIR; i++) f[i] = n.f[i];
    if (n.kind == d2q_pkg::KIND_LID) rho = f[0] + f[2] + f[4] + 2 * (f[3] + f[6] + f[7]);
    else rho = f[0] + f[1] + f[2] + f[3] + f[4] + f[5] + f[6] + f[7] + f[8];
    rho = clamp32(rho);
    if (rho > 0) begin
      if (n.kind == d2q_pkg::KIND_FLUID) begin
        mx = f[2] - f[4] + f[5] + f[6] - f[7] - f[8];
        my = f[3] - f[1] - f[5] + f[6] + f[7] - f[8];
        u = velocity_of(mx, rho);
        v = velocity_of(my, rho);
      end else if (n.kind == d2q_pkg::KIND_LID) begin
        u = lid_q;
      end
    end
    usq = sq_frac(u) + sq_frac(v);
    for (int i = 0; i < NDIR; i++) begin
      num = (i == 0) ? 2 : 1;
      den = (i == 0) ? 9 : (i < 5 ? 18 : 72);
      cu = clamp32(d2q_pkg::DIR_CX[i] * u + d2q_pkg::DIR_CY[i] * v);
      b2 = clamp32((64'sd2 <<< FB) + 6 * cu + 9 * sq_frac(cu) - 3 * usq);
      prod = rho * b2;
      fm = (128'(absval(prod)) * num) / (128'(den) << FB);
      feq = clamp32(prod < 0 ? -$signed(64'(fm)) : $signed(64'(fm)));
      diff = feq - f[i];
      dm = 64'((128'(absval(diff)) * omega_q) >> FB);
      pv = clamp32(f[i] + (diff < 0 ? -$signed(dm) : $signed(dm)));
      res.post[i] = pv[31:0];
    end
    res.rho = rho[31:0];
    res.ux = u[31:0];
    res.uy = v[31:0];
    return res;
  endfunction

  // result checker and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (done) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          $error("result with no request pending");
          errors++;
        end else begin
          coll_t e;
          e = expected_q.pop_front();
          for (int i = 0; i < NDIR; i++)
            if (post[i] !== e.post[i]) begin
              $error("%s: expected %0d, got %0d", post_name[i], e.post[i], post[i]);
              errors++;
            end
          if (density !== e.rho) begin
            $error("density: expected %0d, got %0d", e.rho, density);
            errors++;
          end
          if (vel_x !== e.ux) begin
            $error("vel_x: expected %0d, got %0d", e.ux, vel_x);
            errors++;
          end
          if (vel_y !== e.uy) begin
            $error("vel_y: expected %0d, got %0d", e.uy, vel_y);
            errors++;
          end
        end
      end
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("timeout waiting for accept or result");
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // start stays high between back-to-back requests; it drops only for a gap
  task automatic send_node(input node_t n, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    node_kind <= n.kind;
    for (int i = 0; i < NDIR; i++) dist_in[i] <= n.f[i];
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(collide(n));
    nodes_sent++;
    @(negedge clk);
  endtask

  // drain pipeline, then write a register
  task automatic write_reg(input logic [d2q_pkg::CFG_IDX_W-1:0] idx,
                           input logic [d2q_pkg::CFG_DATA_W-1:0] val);
    start <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (LAT + 2) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == d2q_pkg::REG_RELAX) omega_q = val[d2q_pkg::RELAX_W-1:0];
    else lid_q = val[d2q_pkg::LID_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // physically plausible node: rho near one, small perturbations
  function automatic node_t plausible_node(input logic [d2q_pkg::KIND_W-1:0] k);
    node_t n;
    int w;
    n.kind = k;
    for (int i = 0; i < NDIR; i++) begin
      w = (i == 0) ? 7456540 : (i < 5 ? 1864135 : 466034);
      n.f[i] = w + $signed($urandom_range(0, 400000)) - 200000;
    end
    return n;
  endfunction

  function automatic node_t any_node();
    node_t n;
    n.kind = d2q_pkg::KIND_W'($urandom_range(0, 3));
    for (int i = 0; i < NDIR; i++)
      case ($urandom_range(0, 3))
        0: n.f[i] = $urandom();
        1: n.f[i] = $signed($urandom_range(0, 1 << 26)) - (1 << 25);
        2: n.f[i] = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
        default: n.f[i] = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      endcase
    return n;
  endfunction

  task automatic test_extremes();
    node_t n;
    logic [31:0] pat [4] = '{32'h7FFFFFFF, 32'h80000000, 32'h00000000, 32'hFFFFFFFF};
    for (int k = 0; k < 4; k++)
      for (int p = 0; p < 4; p++) begin
        n.kind = d2q_pkg::KIND_W'(k);
        for (int i = 0; i < NDIR; i++) n.f[i] = pat[(p + i) % 4];
        send_node(n, 0);
      end
    for (int k = 0; k < 4; k++) send_node(plausible_node(d2q_pkg::KIND_W'(k)), 0);
    // zero density and negative density
    n.kind = d2q_pkg::KIND_FLUID;
    for (int i = 0; i < NDIR; i++) n.f[i] = (i == 2) ? 32'sd1000000 : 0;
    n.f[4] = -32'sd1000000;
    send_node(n, 1);
    n.f[0] = -32'sd5000;
    send_node(n, 0);
  endtask

  task automatic test_random(input int count);
    for (int j = 0; j < count; j++) begin
      if ($urandom_range(0, 3) != 0)
        send_node(plausible_node(d2q_pkg::KIND_W'($urandom_range(0, 3))),
                  ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0);
      else send_node(any_node(), $urandom_range(0, 16));
    end
  endtask

  task automatic test_config_sweep();
    logic [31:0] omegas [4] = '{32'd0, 32'd33554432, 32'h3FFFFFF, 32'd16777216};
    logic [31:0] lids [4] = '{32'hFFC00000, 32'h00400000, 32'd0, 32'hFFFFFF};
    for (int s = 0; s < 4; s++) begin
      write_reg(d2q_pkg::REG_RELAX, omegas[s]);
      write_reg(d2q_pkg::REG_LID, lids[s]);
      test_random(100);
    end
  endtask

  initial begin
    omega_q = d2q_pkg::RELAX_RESET;
    lid_q = d2q_pkg::LID_RESET;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    test_extremes();
    test_random(130);
    test_config_sweep();
    start <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (LAT + 5) @(negedge clk);
    $display("covered %0d nodes of all kinds, %0d results checked, omega and lid sweeps",
             nodes_sent, results_seen);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
